>>> rtl/rsie_pkg.sv
// ----------------------------------------------------------------------------
// rsie_pkg
// Shared types and constants for the RV32 subset instruction executor.
// ----------------------------------------------------------------------------
package rsie_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_SYS    = 7'h73;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_JAL    = 7'h6f;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_MUL  = 3'd0;
    localparam logic [2:0] F3_MULH = 3'd1;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_REM  = 3'd6;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BYTE = 3'd0;
    localparam logic [2:0] F3_HALF = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;

    localparam logic [31:0] ECALL_PRINT = 32'd1;
    localparam logic [31:0] ECALL_EXIT  = 32'd10;
    localparam logic [4:0]  REG_A0      = 5'd10;
    localparam logic [4:0]  REG_A1      = 5'd11;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_INSTR = 3'd1,
        ERR_READ  = 3'd2,
        ERR_WRITE = 3'd3,
        ERR_ECALL = 3'd4
    } t_err;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_XOR, ALU_SRL,
        ALU_SRA, ALU_OR, ALU_AND, ALU_MUL, ALU_MULH
    } t_alu_op;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

>>> rtl/rv32_subset_instruction_executor.sv
// ----------------------------------------------------------------------------
// rv32_subset_instruction_executor
// Executes one RV32IM-subset instruction per input beat against a register
// file, program counter and byte-addressed data memory.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one 32-bit instruction per beat. Master channel: one
//   result beat per instruction (next PC, print flag/value, halted, error
//   code, fault address).
//   Steps per instruction, accept to result: read operands, execute,
//   write back, output; stores and loads add a bounds check and a memory
//   phase (one byte per cycle through the single data memory port, load
//   data registered in the RAM), div/rem a wait on the 32-step serial
//   divider. Operands are read one at a time from the register file RAM,
//   in states S_RD1 and S_RD2.
//   One instruction is in flight at a time; the next beat is taken as soon
//   as the previous result sits in the output register, even if the master
//   side is stalled. A result waits in the output register until taken.
//   Reset: registers, PC and halted flag clear at once; the data memory is
//   then cleared one byte per cycle, all 65536 bytes, with tready low.
//   Once halted, every further instruction returns the held PC and halted.
// ----------------------------------------------------------------------------
module rv32_subset_instruction_executor
    import rsie_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // instr_word
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // next_pc[31:0], print_valid[32], print_value[64:33], halted[65],
    // error_code[68:66], fault_address[100:69], zero pad[103:101]
    output logic [103:0] o_m_tdata
);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_RD1    = 10'b0000000100,
        S_RD2    = 10'b0000001000,
        S_EXEC   = 10'b0000010000,
        S_MEMCHK = 10'b0000100000,
        S_MEM    = 10'b0001000000,
        S_DIV    = 10'b0010000000,
        S_WB     = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;
    logic [MEM_AW-1:0] r_clr_addr, n_clr_addr;
    logic [31:0]       r_ir, n_ir;
    logic [31:0]       r_a, n_a;
    logic [31:0]       r_b, n_b;
    logic [31:0]       r_v, n_v;
    logic [31:0]       r_addr, n_addr;
    logic [2:0]        r_cnt, n_cnt;
    logic [31:0]       r_npc, n_npc;
    t_err              r_err, n_err;
    logic [31:0]       r_faddr, n_faddr;
    logic              r_pvalid, n_pvalid;
    logic [31:0]       r_pval, n_pval;
    logic              r_halt, n_halt;
    logic              r_wen, n_wen;
    logic [31:0]       r_pc, n_pc;
    logic              r_stopped, n_stopped;
    logic [31:0]       r_rf_vld, n_rf_vld;
    logic              r_o_valid, n_o_valid;
    logic [31:0]       r_o_npc, n_o_npc;
    logic              r_o_pvalid, n_o_pvalid;
    logic [31:0]       r_o_pval, n_o_pval;
    logic              r_o_halted, n_o_halted;
    t_err              r_o_err, n_o_err;
    logic [31:0]       r_o_faddr, n_o_faddr;

    // decode
    logic [6:0]  opc, f7;
    logic [4:0]  rd, rs1, rs2, rd_a, rd_b;
    logic [2:0]  f3;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    logic [31:0] pc_plus4, pc_tgt;

    assign opc   = r_ir[6:0];
    assign rd    = r_ir[11:7];
    assign f3    = r_ir[14:12];
    assign rs1   = r_ir[19:15];
    assign rs2   = r_ir[24:20];
    assign f7    = r_ir[31:25];
    assign imm_i = {{20{r_ir[31]}}, r_ir[31:20]};
    assign imm_s = {{20{r_ir[31]}}, r_ir[31:25], r_ir[11:7]};
    assign imm_b = {{19{r_ir[31]}}, r_ir[31], r_ir[7], r_ir[30:25], r_ir[11:8], 1'b0};
    assign imm_j = {{11{r_ir[31]}}, r_ir[31], r_ir[19:12], r_ir[20], r_ir[30:21], 1'b0};
    assign imm_u = {r_ir[31:12], 12'd0};
    assign rd_a  = (opc == OP_SYS) ? REG_A0 : rs1;
    assign rd_b  = (opc == OP_SYS) ? REG_A1 : rs2;

    assign pc_plus4 = r_pc + 32'd4;
    assign pc_tgt   = r_pc + ((opc == OP_JAL) ? imm_j : imm_b);

    // register file
    logic        rf_we;
    logic [4:0]  rf_raddr;
    logic [31:0] rf_rdata;

    assign rf_we    = (r_state == S_WB) && r_wen && (rd != 5'd0);
    assign rf_raddr = (r_state == S_IDLE) ?
                      ((i_s_tdata[6:0] == OP_SYS) ? REG_A0 : i_s_tdata[19:15]) : rd_b;

    rsie_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rd),
        .i_wdata (r_v),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    // data memory
    logic [2:0]        mem_len;
    logic [MEM_AW-1:0] mem_baddr;
    logic              dm_we;
    logic [MEM_AW-1:0] dm_waddr;
    logic [7:0]        dm_wdata, dm_rdata;
    logic [32:0]       mem_end;

    assign mem_len   = 3'd1 << f3[1:0];
    assign mem_baddr = r_addr[MEM_AW-1:0] + MEM_AW'(r_cnt);
    assign mem_end   = {1'b0, r_addr} + 33'(mem_len);
    assign dm_we     = (r_state == S_CLEAR) || ((r_state == S_MEM) && (opc == OP_STORE));
    assign dm_waddr  = (r_state == S_CLEAR) ? r_clr_addr : mem_baddr;
    assign dm_wdata  = (r_state == S_CLEAR) ? 8'd0 : r_b[{r_cnt[1:0], 3'b000} +: 8];

    rsie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_raddr (mem_baddr),
        .o_rdata (dm_rdata)
    );

    // shared units
    t_alu_op     alu_op;
    logic [31:0] alu_a, alu_b, alu_y;
    logic        div_start;
    t_div_sts    div_sts;
    logic [31:0] div_quot, div_rem;

    rsie_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    assign div_start = (r_state == S_EXEC) && (opc == OP_REG) && (f7 == F7_MULDIV) &&
                       ((f3 == F3_DIV) || (f3 == F3_REM));

    rsie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_sts   (div_sts),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // operand select for the shared ALU
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = r_a;
        alu_b  = imm_i;
        case (opc)
            OP_REG: begin
                alu_b = r_b;
                if (f7 == F7_MULDIV) begin
                    alu_op = (f3 == F3_MULH) ? ALU_MULH : ALU_MUL;
                end else begin
                    case (f3)
                        F3_ADD:  alu_op = (f7 == F7_ALT) ? ALU_SUB : ALU_ADD;
                        F3_SLL:  alu_op = ALU_SLL;
                        F3_SLT:  alu_op = ALU_SLT;
                        F3_XOR:  alu_op = ALU_XOR;
                        F3_SR:   alu_op = (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
                        F3_OR:   alu_op = ALU_OR;
                        F3_AND:  alu_op = ALU_AND;
                        default: alu_op = ALU_ADD;
                    endcase
                end
            end
            OP_IMM: begin
                case (f3)
                    F3_ADD:  alu_op = ALU_ADD;
                    F3_SLL:  alu_op = ALU_SLL;
                    F3_SLT:  alu_op = ALU_SLT;
                    F3_XOR:  alu_op = ALU_XOR;
                    F3_SR:   alu_op = (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
                    F3_OR:   alu_op = ALU_OR;
                    F3_AND:  alu_op = ALU_AND;
                    default: alu_op = ALU_ADD;
                endcase
            end
            OP_STORE: alu_b = imm_s;
            OP_AUIPC: begin
                alu_a = r_pc;
                alu_b = imm_u;
            end
            OP_LUI: begin
                alu_a = 32'd0;
                alu_b = imm_u;
            end
            default: alu_op = ALU_ADD;
        endcase
    end

    // load byte assembly
    logic [1:0]  ld_idx;
    logic [31:0] ld_word;

    assign ld_idx = r_cnt[1:0] - 2'd1;

    always_comb begin
        ld_word = r_v;
        ld_word[{ld_idx, 3'b000} +: 8] = dm_rdata;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_ir       = r_ir;
        n_a        = r_a;
        n_b        = r_b;
        n_v        = r_v;
        n_addr     = r_addr;
        n_cnt      = r_cnt;
        n_npc      = r_npc;
        n_err      = r_err;
        n_faddr    = r_faddr;
        n_pvalid   = r_pvalid;
        n_pval     = r_pval;
        n_halt     = r_halt;
        n_wen      = r_wen;
        n_pc       = r_pc;
        n_stopped  = r_stopped;
        n_rf_vld   = r_rf_vld;
        n_o_valid  = r_o_valid && !i_m_tready;
        n_o_npc    = r_o_npc;
        n_o_pvalid = r_o_pvalid;
        n_o_pval   = r_o_pval;
        n_o_halted = r_o_halted;
        n_o_err    = r_o_err;
        n_o_faddr  = r_o_faddr;

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + MEM_AW'(1);
                if (r_clr_addr == MEM_AW'(MEM_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_ir     = i_s_tdata;
                    n_npc    = r_pc;
                    n_err    = ERR_NONE;
                    n_faddr  = 32'd0;
                    n_pvalid = 1'b0;
                    n_pval   = 32'd0;
                    n_halt   = r_stopped;
                    n_wen    = 1'b0;
                    n_state  = r_stopped ? S_OUT : S_RD1;
                end
            end
            S_RD1: begin
                n_a     = r_rf_vld[rd_a] ? rf_rdata : 32'd0;
                n_state = S_RD2;
            end
            S_RD2: begin
                n_b     = r_rf_vld[rd_b] ? rf_rdata : 32'd0;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_npc   = pc_plus4;
                n_v     = alu_y;
                n_addr  = alu_y;
                n_state = S_WB;
                case (opc)
                    OP_REG: begin
                        n_wen = 1'b1;
                        if (f7 == F7_BASE) begin
                            if (f3 == 3'd3) begin
                                n_err = ERR_INSTR;
                            end
                        end else if (f7 == F7_MULDIV) begin
                            if ((f3 == F3_DIV) || (f3 == F3_REM)) begin
                                n_state = S_DIV;
                            end else if ((f3 != F3_MUL) && (f3 != F3_MULH)) begin
                                n_err = ERR_INSTR;
                            end
                        end else if (!((f7 == F7_ALT) && ((f3 == F3_ADD) || (f3 == F3_SR)))) begin
                            n_err = ERR_INSTR;
                        end
                    end
                    OP_IMM: begin
                        n_wen = 1'b1;
                        if ((f3 == 3'd3) ||
                            ((f3 == F3_SLL) && (f7 != F7_BASE)) ||
                            ((f3 == F3_SR) && (f7 != F7_BASE) && (f7 != F7_ALT))) begin
                            n_err = ERR_INSTR;
                        end
                    end
                    OP_LOAD, OP_STORE: begin
                        n_wen = (opc == OP_LOAD);
                        if (f3 > F3_WORD) begin
                            n_err = ERR_INSTR;
                        end else begin
                            n_state = S_MEMCHK;
                        end
                    end
                    OP_BRANCH: begin
                        if (f3 == F3_BEQ) begin
                            if (r_a == r_b) n_npc = pc_tgt;
                        end else if (f3 == F3_BNE) begin
                            if (r_a != r_b) n_npc = pc_tgt;
                        end else begin
                            n_err = ERR_INSTR;
                        end
                    end
                    OP_JAL: begin
                        n_wen = 1'b1;
                        n_v   = pc_plus4;
                        n_npc = pc_tgt;
                    end
                    OP_JALR: begin
                        if (f3 != 3'd0) begin
                            n_err = ERR_INSTR;
                        end else begin
                            n_wen = 1'b1;
                            n_v   = pc_plus4;
                            n_npc = {alu_y[31:1], 1'b0};
                        end
                    end
                    OP_AUIPC, OP_LUI: n_wen = 1'b1;
                    OP_SYS: begin
                        if (r_a == ECALL_PRINT) begin
                            n_pvalid = 1'b1;
                            n_pval   = r_b;
                        end else if (r_a == ECALL_EXIT) begin
                            n_halt = 1'b1;
                            n_npc  = r_pc;
                        end else begin
                            n_err = ERR_ECALL;
                        end
                    end
                    default: n_err = ERR_INSTR;
                endcase
                if (n_err != ERR_NONE) begin
                    n_halt  = 1'b1;
                    n_npc   = r_pc;
                    n_wen   = 1'b0;
                    n_state = S_WB;
                end
            end
            S_MEMCHK: begin
                n_cnt = 3'd0;
                n_v   = 32'd0;
                if (mem_end > 33'(MEM_BYTES)) begin
                    n_err   = (opc == OP_LOAD) ? ERR_READ : ERR_WRITE;
                    n_faddr = r_addr;
                    n_halt  = 1'b1;
                    n_npc   = r_pc;
                    n_wen   = 1'b0;
                    n_state = S_WB;
                end else begin
                    n_state = S_MEM;
                end
            end
            S_MEM: begin
                n_cnt = r_cnt + 3'd1;
                if (opc == OP_STORE) begin
                    if (r_cnt == mem_len - 3'd1) begin
                        n_state = S_WB;
                    end
                end else begin
                    // read data arrives in the cycle after its address
                    if (r_cnt != 3'd0) begin
                        n_v = ld_word;
                    end
                    if (r_cnt == mem_len) begin
                        case (f3)
                            F3_BYTE: n_v = {{24{ld_word[7]}}, ld_word[7:0]};
                            F3_HALF: n_v = {{16{ld_word[15]}}, ld_word[15:0]};
                            default: n_v = ld_word;
                        endcase
                        n_state = S_WB;
                    end
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    n_v     = (f3 == F3_DIV) ? div_quot : div_rem;
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (rf_we) begin
                    n_rf_vld[rd] = 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || i_m_tready) begin
                    n_o_valid  = 1'b1;
                    n_o_npc    = r_npc;
                    n_o_pvalid = r_pvalid;
                    n_o_pval   = r_pval;
                    n_o_halted = r_halt;
                    n_o_err    = r_err;
                    n_o_faddr  = r_faddr;
                    n_pc       = r_npc;
                    n_stopped  = r_halt;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_pc       <= '0;
            r_stopped  <= 1'b0;
            r_rf_vld   <= '0;
            r_o_valid  <= 1'b0;
            r_halt     <= 1'b0;
            r_wen      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_pc       <= n_pc;
            r_stopped  <= n_stopped;
            r_rf_vld   <= n_rf_vld;
            r_o_valid  <= n_o_valid;
            r_halt     <= n_halt;
            r_wen      <= n_wen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ir       <= n_ir;
        r_a        <= n_a;
        r_b        <= n_b;
        r_v        <= n_v;
        r_addr     <= n_addr;
        r_cnt      <= n_cnt;
        r_npc      <= n_npc;
        r_err      <= n_err;
        r_faddr    <= n_faddr;
        r_pvalid   <= n_pvalid;
        r_pval     <= n_pval;
        r_o_npc    <= n_o_npc;
        r_o_pvalid <= n_o_pvalid;
        r_o_pval   <= n_o_pval;
        r_o_halted <= n_o_halted;
        r_o_err    <= n_o_err;
        r_o_faddr  <= n_o_faddr;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {3'b000, r_o_faddr, r_o_err, r_o_halted, r_o_pval, r_o_pvalid, r_o_npc};

endmodule

>>> rtl/rsie_ram.sv
// ----------------------------------------------------------------------------
// rsie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rsie_alu.sv
// ----------------------------------------------------------------------------
// rsie_alu
// Shared arithmetic, logic, shift and multiply unit.
// ----------------------------------------------------------------------------
module rsie_alu
    import rsie_pkg::*;
(
    input  t_alu_op     i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    logic signed [65:0] prod;
    logic [4:0]         shamt;

    assign prod  = $signed({i_a[31], i_a}) * $signed({i_b[31], i_b});
    assign shamt = i_b[4:0];

    always_comb begin
        case (i_op)
            ALU_ADD:  o_y = i_a + i_b;
            ALU_SUB:  o_y = i_a - i_b;
            ALU_SLL:  o_y = i_a << shamt;
            ALU_SLT:  o_y = {31'd0, ($signed(i_a) < $signed(i_b))};
            ALU_XOR:  o_y = i_a ^ i_b;
            ALU_SRL:  o_y = i_a >> shamt;
            ALU_SRA:  o_y = 32'($signed(i_a) >>> shamt);
            ALU_OR:   o_y = i_a | i_b;
            ALU_AND:  o_y = i_a & i_b;
            ALU_MUL:  o_y = prod[31:0];
            ALU_MULH: o_y = prod[63:32];
            default:  o_y = i_a + i_b;
        endcase
    end

endmodule

>>> rtl/rsie_div.sv
// ----------------------------------------------------------------------------
// rsie_div
// Signed restoring divider, one quotient bit per cycle, 32 steps.
// ----------------------------------------------------------------------------
module rsie_div
    import rsie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_div_sts    o_sts,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_mb, n_mb;
    logic [31:0] r_a, n_a;
    logic        r_negq, n_negq;
    logic        r_negr, n_negr;
    logic        r_zero, n_zero;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_mb};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_mb   = r_mb;
        n_a    = r_a;
        n_negq = r_negq;
        n_negr = r_negr;
        n_zero = r_zero;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_a[31] ? (32'd0 - i_a) : i_a;
            n_mb   = i_b[31] ? (32'd0 - i_b) : i_b;
            n_a    = i_a;
            n_negq = i_a[31] ^ i_b[31];
            n_negr = i_a[31];
            n_zero = (i_b == 32'd0);
        end else if (r_busy) begin
            if (!diff[32]) begin
                n_rem = diff[31:0];
            end else begin
                n_rem = rem_sh[31:0];
            end
            n_quo = {r_quo[30:0], ~diff[32]};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_mb   <= n_mb;
        r_a    <= n_a;
        r_negq <= n_negq;
        r_negr <= n_negr;
        r_zero <= n_zero;
    end

    // divide by zero: quotient all ones, remainder is the dividend
    assign o_quot = r_zero ? '1  : (r_negq ? (32'd0 - r_quo) : r_quo);
    assign o_rem  = r_zero ? r_a : (r_negr ? (32'd0 - r_rem) : r_rem);

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

>>> rtl/rsie_chk.sv
// ----------------------------------------------------------------------------
// rsie_chk
// Port-level checks for the RV32 subset instruction executor.
// ----------------------------------------------------------------------------
module rsie_chk
    import rsie_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [31:0]  i_s_tdata,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [103:0] o_m_tdata
);

    logic [2:0] err;
    logic       halted, pvalid;

    assign err    = o_m_tdata[68:66];
    assign halted = o_m_tdata[65];
    assign pvalid = o_m_tdata[32];

    // stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat dropped or changed under stall");

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (err != ERR_NONE) |-> halted)
        else $error("error reported without halt");

    a_fault_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[100:69] != 32'd0) |-> (err == ERR_READ || err == ERR_WRITE))
        else $error("fault address without access error");

    a_print_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && pvalid |-> !halted && (err == ERR_NONE))
        else $error("print on a halting beat");

    // accepting an instruction drops tready, so no second one is taken while busy
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second instruction accepted while busy");

endmodule

bind rv32_subset_instruction_executor rsie_chk u_rsie_chk (.*);
